>>> rtl/bdhc_pkg.sv
// bdhc_pkg: shared types and constants of the byte diff hunk chunker
// no dependencies; used by every module of the block

package bdhc_pkg;

  // run start that would read as the end-of-file marker
  localparam logic [31:0] EOF_MARK_OFFSET = 32'h4545_4F46;
  // reset value of the chunk length limit
  localparam logic [15:0] MAX_LEN_RESET   = 16'hFFFF;
  // configuration register address width and register indexes
  localparam int unsigned CFG_AW          = 3;
  localparam logic [CFG_AW-1:0] REG_MAX_CHUNK_LENGTH = 3'd0;

  // running state of the chunker
  typedef struct packed {
    logic [32:0] pos;     // position of the next pair, saturates at 2^32
    logic        in_run;  // a run of differing bytes is open
    logic [31:0] start;   // offset of the chunk being built
    logic [15:0] count;   // bytes in the chunk being built
  } chunk_state_t;

  // result of one step
  typedef struct packed {
    logic        emit;
    logic [31:0] offset;
    logic [15:0] length;
  } chunk_result_t;

endpackage

>>> rtl/byte_diff_hunk_chunker_core.sv
// byte_diff_hunk_chunker_core: top level of the patch hunk chunker
// depends on bdhc_pkg, bdhc_cfg and bdhc_step
//
// Usage:
// - input channel (in_valid/in_ready) carries one byte pair per item: a byte of the
//   original stream, the byte at the same position of the patched stream, and a flag
//   marking the last pair of the streams
// - result channel (out_valid/out_ready) carries chunk descriptors (offset, length);
//   an item gives zero or one descriptor
// - the apb-style port holds max_chunk_length at address 0 (reset 65535, 0 acts as 1);
//   write it only while the block is idle
// - throughput: one item per cycle while the receiver keeps up; the step logic between
//   the input register and the result register is combinational
// - a descriptor passes the input register and then the result register to out_valid
// - a stalled receiver holds the result register; the input register still takes one
//   more item, then in_ready drops until the result is taken
// - reset clears the position, the open run and both pipeline valids, and loads the
//   limit with 65535
// - after the last pair the position rewinds to 0 for the next stream pair

module byte_diff_hunk_chunker_core
  import bdhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_original_byte,
  input  logic [7:0]        in_patched_byte,
  input  logic              in_final_pair,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_chunk_offset,
  output logic [15:0]       out_chunk_length,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0]   max_len;
  logic          s1_valid_r;
  logic          s1_valid_nxt;
  logic [7:0]    s1_orig_r;
  logic [7:0]    s1_patch_r;
  logic          s1_final_r;
  logic          adv;
  logic          in_acc;
  chunk_state_t  state_r;
  chunk_state_t  state_nxt;
  chunk_result_t step_res;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [31:0]   out_offset_r;
  logic [15:0]   out_length_r;

  bdhc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  bdhc_step u_step (
    .cur           (state_r),
    .max_len       (max_len),
    .original_byte (s1_orig_r),
    .patched_byte  (s1_patch_r),
    .final_pair    (s1_final_r),
    .nxt           (state_nxt),
    .res           (step_res)
  );

  // the held item moves on when the result register has room
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_acc   = in_valid && in_ready;

  // input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_orig_r  <= in_original_byte;
      s1_patch_r <= in_patched_byte;
      s1_final_r <= in_final_pair;
    end
  end

  // chunker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv && step_res.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && step_res.emit) begin
      out_offset_r <= step_res.offset;
      out_length_r <= step_res.length;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chunk_offset = out_offset_r;
  assign out_chunk_length = out_length_r;

  // a descriptor never carries an empty chunk
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_length_r != 16'h0000)
    else $error("empty chunk emitted");

  // the last pair rewinds position and closes the run
  a_final_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_final_r) |=> (state_r.pos == 33'h0 && !state_r.in_run))
    else $error("final pair did not rewind");

  // saturated position sits exactly at 2^32
  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pos[32] |-> state_r.pos[31:0] == 32'h0000_0000)
    else $error("position passed 2^32");

  // no byte count without an open run
  a_count_run: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.in_run |-> state_r.count == 16'h0000)
    else $error("count held outside a run");

  // a result waiting on a stalled receiver is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !adv)
    else $error("result register overwritten");

endmodule

>>> rtl/bdhc_cfg.sv
// bdhc_cfg: apb-style register port holding the chunk length limit
// depends on bdhc_pkg

module bdhc_cfg
  import bdhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [15:0]       max_len
);

  logic [15:0] max_len_r;
  logic [15:0] max_len_nxt;
  logic        wr_en;

  assign pready = 1'b1;

  // register write on the access cycle
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    max_len_nxt = max_len_r;
    if (wr_en && paddr == REG_MAX_CHUNK_LENGTH) begin
      max_len_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  // read decode
  always_comb begin
    unique case (paddr)
      REG_MAX_CHUNK_LENGTH: prdata = {16'h0000, max_len_r};
      default:              prdata = 32'h0000_0000;
    endcase
  end

  assign max_len = max_len_r;

endmodule

>>> rtl/bdhc_step.sv
// bdhc_step: one byte pair against the running state, giving next state and result
// depends on bdhc_pkg

module bdhc_step
  import bdhc_pkg::*;
(
  input  chunk_state_t  cur,
  input  logic [15:0]   max_len,
  input  logic [7:0]    original_byte,
  input  logic [7:0]    patched_byte,
  input  logic          final_pair,
  output chunk_state_t  nxt,
  output chunk_result_t res
);

  logic [15:0] limit;
  logic [31:0] pos32;
  logic        differ;
  logic        active;
  logic [15:0] cnt;

  assign limit  = (max_len == 16'h0000) ? 16'h0001 : max_len;
  assign pos32  = cur.pos[31:0];
  assign differ = original_byte != patched_byte;
  assign active = !cur.pos[32];

  always_comb begin
    nxt = cur;
    res = '0;
    cnt = cur.count;
    if (active) begin
      if (cur.in_run && !differ) begin
        // run ends: flush any open chunk
        if (cur.count != 16'h0000) begin
          res.emit   = 1'b1;
          res.offset = cur.start;
          res.length = cur.count;
        end
        nxt.in_run = 1'b0;
        nxt.count  = 16'h0000;
      end else if (differ) begin
        if (cur.in_run) begin
          cnt = cur.count + 16'd1;
        end else begin
          // new run, moved off the eof marker when needed
          nxt.in_run = 1'b1;
          if (pos32 == EOF_MARK_OFFSET) begin
            nxt.start = pos32 - 32'd1;
            cnt       = 16'd2;
          end else begin
            nxt.start = pos32;
            cnt       = 16'd1;
          end
        end
        nxt.count = cnt;
        // chunk full: emit and restart after this byte
        if (cnt >= limit) begin
          res.emit   = 1'b1;
          res.offset = nxt.start;
          res.length = cnt;
          nxt.start  = pos32 + 32'd1;
          nxt.count  = 16'h0000;
        end
      end
      nxt.pos = cur.pos + 33'd1;
    end
    // last pair: flush and rewind
    if (final_pair) begin
      if (nxt.in_run && nxt.count != 16'h0000 && !res.emit) begin
        res.emit   = 1'b1;
        res.offset = nxt.start;
        res.length = nxt.count;
      end
      nxt.in_run = 1'b0;
      nxt.count  = 16'h0000;
      nxt.start  = 32'h0000_0000;
      nxt.pos    = 33'h0_0000_0000;
    end
  end

endmodule
